// ===== rtl/psa_pkg.sv =====
// Package for the priority slot allocator: sizes, request and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package psa_pkg;

	// Pool geometry
	localparam int SLOTS_PER_POOL = 32;
	localparam int SLOT_W         = 5;
	localparam int CNT_W          = 6;
	localparam int PRIO_IN_W      = 8;
	localparam int PRIO_W         = 9;
	localparam int RAM_DEPTH      = 2 * SLOTS_PER_POOL;
	localparam int RAM_AW         = $clog2(RAM_DEPTH);

	// Request types
	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_FREE   = 2'd1;
	localparam logic [1:0] REQ_UPDATE = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOALLOC = 2'd2;

	// Stored priority of a free slot (-1)
	localparam logic [PRIO_W-1:0] PRIO_FREE = '1;

	// Configuration registers
	localparam logic              REG_GENERIC_LIMIT = 1'b0;
	localparam logic              REG_CUBE_LIMIT    = 1'b1;
	localparam logic [CNT_W-1:0]  LIMIT_RESET       = CNT_W'(32);

	typedef struct packed {
		logic load;    // capture the accepted item, restart the scan
		logic step;    // advance the slot scan by one read
		logic finish;  // commit the update and load the result register
	} psa_cmd_t;

	typedef struct packed {
		logic is_scan;    // held item is a slot request
		logic scan_done;  // scan found a slot or ran past the count
		logic out_free;   // result register can take a new item
	} psa_sts_t;

endpackage

// ===== rtl/priority_slot_allocator_unit.sv =====
// Priority slot allocator, top level: stream ports, APB limit registers,
// controller and datapath. Depends on psa_pkg, psa_ctrl, psa_dp.
//
// Usage: each item on the s_ channel is a slot request, a free or an update
// for one of two pools (generic, cube); each produces exactly one result item
// on the m_ channel. The limits of the two pools are set through the APB port
// (generic_limit at 0x0, cube_limit at 0x4); the user must write them only
// while the block is idle, which the block itself does not enforce.
// A request reads the pool's allocated slots one per cycle from the priority
// RAM, a rate set by its single read port; the scan stops once a slot qualifies.
// Free, update and unused request types skip the scan. One item is worked at
// a time; s_tready is high only while the controller is idle.
// Reset clears both pool counts, sets both limits to 32 and drops any result;
// the priority RAM needs no clearing, as only allocated slots are read.
// When the receiver stalls, the result stays in the output register and the
// next item is still accepted and worked on; it waits at its finish step
// until the output register is free.
module priority_slot_allocator_unit
	import psa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // priority_req[7:0], slot_index[12:8], zero[15:13]
	input  logic [2:0]  s_tuser,   // req_type[1:0], pool[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // slot[4:0], fresh[5], preempted[6], evicted_priority[15:7]
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	psa_cmd_t cmd;
	psa_sts_t sts;

	logic [CNT_W-1:0]  generic_limit_q;
	logic [CNT_W-1:0]  cube_limit_q;
	logic              cfg_wr;
	logic [SLOT_W-1:0] res_slot;
	logic              res_fresh;
	logic              res_pre;
	logic [PRIO_W-1:0] res_ev;

	// Limit registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			generic_limit_q <= LIMIT_RESET;
			cube_limit_q    <= LIMIT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_GENERIC_LIMIT) begin
				generic_limit_q <= pwdata[CNT_W-1:0];
			end else begin
				cube_limit_q <= pwdata[CNT_W-1:0];
			end
		end
	end

	// Register read-back
	always_comb begin
		case (paddr[2])
			REG_GENERIC_LIMIT: prdata = {{(32-CNT_W){1'b0}}, generic_limit_q};
			REG_CUBE_LIMIT:    prdata = {{(32-CNT_W){1'b0}}, cube_limit_q};
			default:           prdata = '0;
		endcase
	end

	psa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	psa_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.in_req_type         (s_tuser[1:0]),
		.in_pool             (s_tuser[2]),
		.in_priority_req     (s_tdata[7:0]),
		.in_slot_index       (s_tdata[12:8]),
		.generic_limit       (generic_limit_q),
		.cube_limit          (cube_limit_q),
		.out_valid           (m_tvalid),
		.out_ready           (m_tready),
		.out_status          (m_tuser),
		.out_slot            (res_slot),
		.out_fresh           (res_fresh),
		.out_preempted       (res_pre),
		.out_evicted_priority(res_ev)
	);

	// Pack the result item
	assign m_tdata = {res_ev, res_pre, res_fresh, res_slot};

`ifndef SYNTH
	// An accepted item blocks further input until it is finished
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in work");

	// Finish only when the result register can take the item
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// A finished item shows up as a result in the next cycle
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid)
		else $error("finished item not presented");

	// Capture and commit never overlap
	a_load_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && (cmd.finish || cmd.step)))
		else $error("controller commands overlap");
`endif

endmodule

// ===== rtl/psa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psa_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/psa_ctrl.sv =====
// Controller for the priority slot allocator: sequences accept, scan and
// finish. Depends on psa_pkg.
module psa_ctrl
	import psa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  psa_sts_t sts,
	output psa_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!sts.is_scan) begin
					state_d = S_FIN;
				end else begin
					cmd.step = 1'b1;
					if (sts.scan_done) begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				// Hold until the result register is free
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/psa_dp.sv =====
// Datapath for the priority slot allocator: held item, slot priority RAM,
// pool counts, scan compare and result register. Depends on psa_pkg, psa_ram.
module psa_dp
	import psa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  psa_cmd_t             cmd,
	output psa_sts_t             sts,
	input  logic [1:0]           in_req_type,
	input  logic                 in_pool,
	input  logic [PRIO_IN_W-1:0] in_priority_req,
	input  logic [SLOT_W-1:0]    in_slot_index,
	input  logic [CNT_W-1:0]     generic_limit,
	input  logic [CNT_W-1:0]     cube_limit,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           out_status,
	output logic [SLOT_W-1:0]    out_slot,
	output logic                 out_fresh,
	output logic                 out_preempted,
	output logic [PRIO_W-1:0]    out_evicted_priority
);

	// Held item
	logic [1:0]           type_q;
	logic                 pool_q;
	logic [PRIO_IN_W-1:0] prio_q;
	logic [SLOT_W-1:0]    idx_q;

	// Pool counts
	logic [CNT_W-1:0] gcnt_q;
	logic [CNT_W-1:0] ccnt_q;

	// Scan state
	logic [CNT_W-1:0]  scan_q;
	logic              pend_q;
	logic [SLOT_W-1:0] sidx_s1;
	logic              hit_q;
	logic [SLOT_W-1:0] hit_idx_q;
	logic [PRIO_W-1:0] old_q;

	// Result register
	logic              valid_q;
	logic [1:0]        status_q;
	logic [SLOT_W-1:0] slot_q;
	logic              fresh_q;
	logic              pre_q;
	logic [PRIO_W-1:0] ev_q;

	// RAM ports
	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [PRIO_W-1:0] ram_wdata;
	logic              ram_re;
	logic [RAM_AW-1:0] ram_raddr;
	logic [PRIO_W-1:0] ram_rdata;

	logic [CNT_W-1:0]  cur_cnt;
	logic [CNT_W-1:0]  cur_lim;
	logic [CNT_W-1:0]  eff_lim;
	logic              more;
	logic              hit_now;
	logic              cnt_inc;
	logic [1:0]        res_status;
	logic [SLOT_W-1:0] res_slot;
	logic              res_fresh;
	logic              res_pre;
	logic [PRIO_W-1:0] res_ev;

	psa_ram #(
		.WIDTH(PRIO_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Pool selection and effective limit
	assign cur_cnt = pool_q ? ccnt_q : gcnt_q;
	assign cur_lim = pool_q ? cube_limit : generic_limit;
	assign eff_lim = (cur_lim > CNT_W'(SLOTS_PER_POOL)) ? CNT_W'(SLOTS_PER_POOL) : cur_lim;

	// Scan compare on the slot read in the previous cycle
	assign more    = scan_q < cur_cnt;
	assign hit_now = pend_q && ($signed({1'b0, prio_q}) > $signed(ram_rdata));
	assign ram_re    = cmd.step && more && !hit_now;
	assign ram_raddr = {pool_q, scan_q[SLOT_W-1:0]};

	assign sts.is_scan   = (type_q == REQ_ALLOC);
	assign sts.scan_done = hit_now || (!pend_q && !more);
	assign sts.out_free  = !valid_q || out_ready;

	// Result and write-back of the held item
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = {pool_q, idx_q};
		ram_wdata  = {1'b0, prio_q};
		cnt_inc    = 1'b0;
		res_status = ST_OK;
		res_slot   = '0;
		res_fresh  = 1'b0;
		res_pre    = 1'b0;
		res_ev     = '0;
		case (type_q)
			REQ_ALLOC: begin
				if (hit_q) begin
					ram_we    = 1'b1;
					ram_waddr = {pool_q, hit_idx_q};
					res_slot  = hit_idx_q;
					res_pre   = (old_q != PRIO_FREE);
					res_ev    = old_q;
				end else if (cur_cnt < eff_lim) begin
					ram_we    = 1'b1;
					ram_waddr = {pool_q, cur_cnt[SLOT_W-1:0]};
					cnt_inc   = 1'b1;
					res_slot  = cur_cnt[SLOT_W-1:0];
					res_fresh = 1'b1;
					res_ev    = PRIO_FREE;
				end else begin
					res_status = ST_FULL;
				end
			end
			REQ_FREE, REQ_UPDATE: begin
				res_slot = idx_q;
				if ({1'b0, idx_q} < cur_cnt) begin
					ram_we    = 1'b1;
					ram_wdata = (type_q == REQ_FREE) ? PRIO_FREE : {1'b0, prio_q};
				end else begin
					res_status = ST_NOALLOC;
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
		ram_we  = ram_we && cmd.finish;
		cnt_inc = cnt_inc && cmd.finish;
	end

	// Capture the item and advance the scan
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= in_req_type;
			pool_q <= in_pool;
			prio_q <= in_priority_req;
			idx_q  <= in_slot_index;
		end
		if (cmd.step && hit_now) begin
			hit_idx_q <= sidx_s1;
			old_q     <= ram_rdata;
		end else if (cmd.step && more) begin
			sidx_s1 <= scan_q[SLOT_W-1:0];
		end
		if (cmd.finish) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			fresh_q  <= res_fresh;
			pre_q    <= res_pre;
			ev_q     <= res_ev;
		end
	end

	// Scan control, counts and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			pend_q  <= 1'b0;
			hit_q   <= 1'b0;
			gcnt_q  <= '0;
			ccnt_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_q <= '0;
				pend_q <= 1'b0;
				hit_q  <= 1'b0;
			end else if (cmd.step) begin
				if (hit_now) begin
					hit_q  <= 1'b1;
					pend_q <= 1'b0;
				end else if (more) begin
					pend_q <= 1'b1;
					scan_q <= scan_q + CNT_W'(1);
				end else begin
					pend_q <= 1'b0;
				end
			end
			if (cnt_inc) begin
				if (pool_q) begin
					ccnt_q <= ccnt_q + CNT_W'(1);
				end else begin
					gcnt_q <= gcnt_q + CNT_W'(1);
				end
			end
			if (cmd.finish) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid            = valid_q;
	assign out_status           = status_q;
	assign out_slot             = slot_q;
	assign out_fresh            = fresh_q;
	assign out_preempted        = pre_q;
	assign out_evicted_priority = ev_q;

endmodule
